>>> rtl/rmdp_pkg.sv
// ----------------------------------------------------------------------------
// rmdp_pkg
// Shared types and constants for the row matcher with duplicate removal.
// ----------------------------------------------------------------------------
package rmdp_pkg;
	localparam int MAX_ROWS   = 256;
	localparam int MAX_COLS   = 8;
	localparam int VALUE_BITS = 32;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int CNT_W      = ROW_W + 1;
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int CFG_W      = 4;

	typedef enum logic [1:0] {
		CMD_DATA   = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_DRAIN  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		K_SAMPLE_KEPT    = 3'd0,
		K_SAMPLE_MATCHED = 3'd1,
		K_DATA_MOVED     = 3'd2,
		K_DATA_KEPT      = 3'd3,
		K_ERROR          = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_RD,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic             load;
		logic [COL_W-1:0] load_col;
		logic             shift;
		logic [CFG_W-1:0] cols;
	} chain_ctrl_t;
endpackage

>>> rtl/rmdp_ram.sv
// ----------------------------------------------------------------------------
// rmdp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rmdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

>>> rtl/rmdp_cell.sv
// ----------------------------------------------------------------------------
// rmdp_cell
// One column slot of the sample ring: loads a value or takes its neighbor's.
// ----------------------------------------------------------------------------
module rmdp_cell (
	input  logic                            clk,
	input  logic                            load,
	input  logic [rmdp_pkg::VALUE_BITS-1:0] load_val,
	input  logic                            shift,
	input  logic [rmdp_pkg::VALUE_BITS-1:0] next_val,
	output logic [rmdp_pkg::VALUE_BITS-1:0] val_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end else if (shift) begin
			val_q <= next_val;
		end
	end
endmodule

>>> rtl/rmdp_chain.sv
// ----------------------------------------------------------------------------
// rmdp_chain
// Ring of sample cells; the head cell always shows the column under compare.
// ----------------------------------------------------------------------------
module rmdp_chain (
	input  logic                            clk,
	input  rmdp_pkg::chain_ctrl_t           ctrl,
	input  logic [rmdp_pkg::VALUE_BITS-1:0] load_val,
	output logic [rmdp_pkg::VALUE_BITS-1:0] head
);
	import rmdp_pkg::*;

	logic [VALUE_BITS-1:0] vals [MAX_COLS];

	for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
		logic [VALUE_BITS-1:0] nxt;
		logic                  ld;
		logic                  sh;

		if (i == MAX_COLS - 1) begin : g_end
			assign nxt = vals[0];
		end else begin : g_mid
			assign nxt = (ctrl.cols == CFG_W'(i + 1)) ? vals[0] : vals[i + 1];
		end
		assign ld = ctrl.load && (ctrl.load_col == COL_W'(i));
		assign sh = ctrl.shift && (CFG_W'(i) < ctrl.cols);

		rmdp_cell u_cell (
			.clk      (clk),
			.load     (ld),
			.load_val (load_val),
			.shift    (sh),
			.next_val (nxt),
			.val_q    (vals[i])
		);
	end

	assign head = vals[0];
endmodule

>>> rtl/row_match_dedup_partition_top.sv
// Data, drain and clear items are taken while idle and never raise busy; a
// result, where one is due, shows on the cycle after the item is accepted.
// A completing sample item scans the row store: used rows are skipped, and
// each column of a candidate row is read from the RAM, then compared; the
// scan stops at the first matching row, and busy covers the whole scan.
// Reset clears all counters and used flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// row_match_dedup_partition_top
// Matches sample rows against stored data rows and reports perm positions.
// ----------------------------------------------------------------------------
module row_match_dedup_partition_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      cmd,
	input  logic signed [31:0]              value,
	input  logic                            cfg_we,
	input  logic [rmdp_pkg::CFG_W-1:0]      cfg_data,
	output logic                            done,
	output logic [2:0]                      kind,
	output logic [15:0]                     sample_row,
	output logic [7:0]                      data_row,
	output logic [15:0]                     position,
	output logic                            last_row
);
	import rmdp_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0]      cols_q;
	logic [COL_W-1:0]      cc_q;
	logic                  pk_q;
	logic [CNT_W-1:0]      drc_q, mc_q, dp_q, kdc_q, j_q;
	logic [15:0]           src_q, ksc_q;
	logic [COL_W-1:0]      k_q;
	logic                  mm_q;
	logic [MAX_ROWS-1:0]   used_q;

	logic [CFG_W-1:0]      ec;
	logic                  acc;
	logic [CFG_W-1:0]      cc0;
	logic                  row_end;
	logic                  store_full;
	logic [VALUE_BITS-1:0] vbits;
	logic [VALUE_BITS-1:0] rdata;
	logic [VALUE_BITS-1:0] head;
	logic                  ram_we, ram_re;
	logic [ADDR_W-1:0]     ram_addr;
	chain_ctrl_t           cc_ctrl;
	logic                  last_col, mm_new;
	logic [16:0]           mv_pos;
	logic [CNT_W-1:0]      dp_inc;

	logic                  res_v;
	kind_t                 res_kind;
	logic [15:0]           res_srow, res_pos;
	logic [ROW_W-1:0]      res_drow;
	logic                  res_last;

	assign ec = (cols_q == '0) ? CFG_W'(1) :
		(cols_q > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_q;
	assign busy = (state_q != ST_IDLE);
	assign acc = start && !busy;
	assign vbits = value[VALUE_BITS-1:0];
	assign dp_inc = dp_q + 1'b1;

	always_comb begin
		cc0 = {1'b0, cc_q};
		if (cc_q != '0 && pk_q != cmd[0]) begin
			cc0 = '0;
		end
		if (cc0 >= ec) begin
			cc0 = '0;
		end
	end
	assign row_end = (cc0 + 1'b1) >= ec;
	assign store_full = (drc_q >= CNT_W'(MAX_ROWS));
	assign last_col = ({1'b0, k_q} + 1'b1) == ec;
	assign mm_new = mm_q || (rdata != head);
	assign mv_pos = {1'b0, ksc_q} + 17'(dp_q - kdc_q);

	always_comb begin
		ram_we = acc && (cmd == CMD_DATA) && !store_full;
		ram_re = (state_q == ST_RD);
		ram_addr = ram_re ? {j_q[ROW_W-1:0], k_q} : {drc_q[ROW_W-1:0], cc0[COL_W-1:0]};
	end

	always_comb begin
		cc_ctrl.load = acc && (cmd == CMD_SAMPLE);
		cc_ctrl.load_col = cc0[COL_W-1:0];
		cc_ctrl.shift = (state_q == ST_CMP);
		cc_ctrl.cols = ec;
	end

	rmdp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS * MAX_COLS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (vbits),
		.rdata (rdata)
	);

	rmdp_chain u_chain (
		.clk      (clk),
		.ctrl     (cc_ctrl),
		.load_val (vbits),
		.head     (head)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_SAMPLE && row_end) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				if (j_q >= drc_q) begin
					state_d = ST_IDLE;
				end else if (!used_q[j_q[ROW_W-1:0]]) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (last_col) begin
					state_d = mm_new ? ST_ROW : ST_IDLE;
				end else begin
					state_d = ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		res_v = 1'b0;
		res_kind = K_ERROR;
		res_srow = '0;
		res_drow = '0;
		res_pos = '0;
		res_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_DATA && store_full) begin
					res_v = 1'b1;
				end else if (acc && cmd == CMD_DRAIN) begin
					res_v = 1'b1;
					if (dp_q < drc_q) begin
						if (!used_q[dp_q[ROW_W-1:0]]) begin
							res_kind = K_DATA_KEPT;
							res_drow = dp_q[ROW_W-1:0];
							res_pos = 16'(kdc_q);
							res_last = (dp_inc == drc_q);
						end else if (!mv_pos[16]) begin
							res_kind = K_DATA_MOVED;
							res_drow = dp_q[ROW_W-1:0];
							res_pos = mv_pos[15:0];
							res_last = (dp_inc == drc_q);
						end
					end
				end
			end
			ST_ROW: begin
				if (j_q >= drc_q) begin
					res_v = 1'b1;
					if (ksc_q != 16'hFFFF) begin
						res_kind = K_SAMPLE_KEPT;
						res_srow = src_q;
						res_pos = ksc_q;
					end
				end
			end
			ST_CMP: begin
				if (last_col && !mm_new) begin
					res_v = 1'b1;
					res_kind = K_SAMPLE_MATCHED;
					res_srow = src_q;
					res_drow = j_q[ROW_W-1:0];
					res_pos = 16'(mc_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cols_q <= CFG_W'(MAX_COLS);
			cc_q <= '0;
			pk_q <= 1'b0;
			drc_q <= '0;
			mc_q <= '0;
			dp_q <= '0;
			kdc_q <= '0;
			src_q <= '0;
			ksc_q <= '0;
			used_q <= '0;
			j_q <= '0;
			k_q <= '0;
			mm_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= res_v;
			if (cfg_we) begin
				cols_q <= cfg_data;
				if (!(acc && cmd != CMD_DRAIN)) begin
					cc_q <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (cmd)
							CMD_CLEAR: begin
								cc_q <= '0;
								pk_q <= 1'b0;
								drc_q <= '0;
								mc_q <= '0;
								dp_q <= '0;
								kdc_q <= '0;
								src_q <= '0;
								ksc_q <= '0;
								used_q <= '0;
							end
							CMD_DRAIN: begin
								if (dp_q < drc_q) begin
									if (!used_q[dp_q[ROW_W-1:0]]) begin
										kdc_q <= kdc_q + 1'b1;
										dp_q <= dp_inc;
									end else if (!mv_pos[16]) begin
										dp_q <= dp_inc;
									end
								end
							end
							CMD_DATA: begin
								pk_q <= 1'b0;
								if (store_full) begin
									cc_q <= cc0[COL_W-1:0];
								end else if (row_end) begin
									cc_q <= '0;
									drc_q <= drc_q + 1'b1;
								end else begin
									cc_q <= COL_W'(cc0 + 1'b1);
								end
							end
							CMD_SAMPLE: begin
								pk_q <= 1'b1;
								if (row_end) begin
									cc_q <= '0;
									j_q <= '0;
								end else begin
									cc_q <= COL_W'(cc0 + 1'b1);
								end
							end
							default: ;
						endcase
					end
				end
				ST_ROW: begin
					if (j_q >= drc_q) begin
						if (ksc_q != 16'hFFFF) begin
							ksc_q <= ksc_q + 1'b1;
							if (src_q != 16'hFFFF) begin
								src_q <= src_q + 1'b1;
							end
						end
					end else if (used_q[j_q[ROW_W-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else begin
						k_q <= '0;
						mm_q <= 1'b0;
					end
				end
				ST_RD: ;
				ST_CMP: begin
					mm_q <= mm_new;
					if (last_col) begin
						if (mm_new) begin
							j_q <= j_q + 1'b1;
						end else begin
							used_q[j_q[ROW_W-1:0]] <= 1'b1;
							mc_q <= mc_q + 1'b1;
							if (src_q != 16'hFFFF) begin
								src_q <= src_q + 1'b1;
							end
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kind <= res_kind;
		sample_row <= res_srow;
		data_row <= res_drow;
		position <= res_pos;
		last_row <= res_last;
	end
endmodule

>>> rtl/rmdp_checker.sv
// ----------------------------------------------------------------------------
// rmdp_checker
// Port-level checks for the row matcher, bound to the top level.
// ----------------------------------------------------------------------------
module rmdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  cmd,
	input logic        done,
	input logic [2:0]  kind,
	input logic [15:0] sample_row,
	input logic [7:0]  data_row,
	input logic [15:0] position,
	input logic        last_row
);
	import rmdp_pkg::*;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind == K_ERROR |-> sample_row == '0 && data_row == '0 &&
		position == '0 && !last_row)
		else $error("error item carries nonzero fields");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_CLEAR |=> !done)
		else $error("clear produced an item");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && cmd == CMD_SAMPLE))
		else $error("busy without a sample item");

	a_sample_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind == K_SAMPLE_KEPT || kind == K_SAMPLE_MATCHED) |-> !last_row)
		else $error("last_row on a sample item");
endmodule

bind row_match_dedup_partition_top rmdp_checker u_rmdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cmd        (cmd),
	.done       (done),
	.kind       (kind),
	.sample_row (sample_row),
	.data_row   (data_row),
	.position   (position),
	.last_row   (last_row)
);

>>> test/rmdp_checker.sv
// ----------------------------------------------------------------------------
// rmdp_scoreboard
// Watches the item, result and register ports of the row matcher. It keeps its
// own row store, used flags and counters, works out the result of every
// accepted item and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module rmdp_scoreboard (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic signed [31:0]           value,
	input  logic                         cfg_we,
	input  logic [rmdp_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         done,
	input  logic [2:0]                   kind,
	input  logic [15:0]                  sample_row,
	input  logic [7:0]                   data_row,
	input  logic [15:0]                  position,
	input  logic                         last_row,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rmdp_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [15:0] srow;
		logic [7:0]  drow;
		logic [15:0] pos;
		logic        last;
	} match_result_t;

	match_result_t outcomes[$];

	logic [31:0]  rows[MAX_ROWS][MAX_COLS];
	logic         used[MAX_ROWS];
	logic [31:0]  sbuf[MAX_COLS];
	logic [CFG_W-1:0] cols_reg;
	int unsigned  col_cnt, part_kind, n_rows, n_samp, n_kept_s, n_match, drain_ptr, n_kept_d;

	assign pending = outcomes.size();

	function automatic int unsigned width_now();
		if (cols_reg < 1) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return cols_reg;
	endfunction

	task automatic wipe_counters();
		for (int i = 0; i < MAX_ROWS; i++) used[i] = 1'b0;
		col_cnt = 0;
		part_kind = 0;
		n_rows = 0;
		n_samp = 0;
		n_kept_s = 0;
		n_match = 0;
		drain_ptr = 0;
		n_kept_d = 0;
	endtask

	task automatic post(kind_t k, int unsigned s, int unsigned d, int unsigned p, bit l);
		match_result_t r;
		r.kind = k;
		r.srow = s[15:0];
		r.drow = d[7:0];
		r.pos = p[15:0];
		r.last = l;
		outcomes.push_back(r);
	endtask

	task automatic close_sample();
		int unsigned w;
		int unsigned k;
		w = width_now();
		for (int unsigned j = 0; j < n_rows && j < MAX_ROWS; j++) begin
			if (used[j]) continue;
			for (k = 0; k < w; k++)
				if (sbuf[k] != rows[j][k]) break;
			if (k == w) begin
				used[j] = 1'b1;
				post(K_SAMPLE_MATCHED, n_samp, j, n_match, 0);
				n_match++;
				if (n_samp < 16'hFFFF) n_samp++;
				return;
			end
		end
		if (n_kept_s >= 16'hFFFF) begin
			post(K_ERROR, 0, 0, 0, 0);
			return;
		end
		post(K_SAMPLE_KEPT, n_samp, 0, n_kept_s, 0);
		n_kept_s++;
		if (n_samp < 16'hFFFF) n_samp++;
	endtask

	task automatic apply_item(cmd_t c, logic [31:0] v);
		int unsigned w;
		int unsigned p;
		bit l;
		w = width_now();
		if (c == CMD_CLEAR) begin
			wipe_counters();
			return;
		end
		if (c == CMD_DRAIN) begin
			if (drain_ptr >= n_rows || drain_ptr >= MAX_ROWS) begin
				post(K_ERROR, 0, 0, 0, 0);
				return;
			end
			l = (drain_ptr + 1 == n_rows);
			if (used[drain_ptr]) begin
				p = n_kept_s + (drain_ptr - n_kept_d);
				if (p > 16'hFFFF) begin
					post(K_ERROR, 0, 0, 0, 0);
					return;
				end
				post(K_DATA_MOVED, 0, drain_ptr, p, l);
			end else begin
				post(K_DATA_KEPT, 0, drain_ptr, n_kept_d, l);
				n_kept_d++;
			end
			drain_ptr++;
			return;
		end
		if (col_cnt != 0 && part_kind != c) col_cnt = 0;
		part_kind = c;
		if (col_cnt >= w) col_cnt = 0;
		if (c == CMD_DATA) begin
			if (n_rows >= MAX_ROWS) begin
				post(K_ERROR, 0, 0, 0, 0);
				return;
			end
			rows[n_rows][col_cnt] = v;
			col_cnt++;
			if (col_cnt >= w) begin
				col_cnt = 0;
				n_rows++;
			end
			return;
		end
		sbuf[col_cnt] = v;
		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			close_sample();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_result_t e;
		if (!arst_n) begin
			wipe_counters();
			cols_reg = 4'd8;
			outcomes.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (outcomes.size() == 0) begin
					$error("result with no item waiting for it: kind %0d", kind);
					errors++;
				end else begin
					e = outcomes.pop_front();
					if (kind !== e.kind) begin
						$error("kind: expected %0d, actual %0d", e.kind, kind);
						errors++;
					end
					if (sample_row !== e.srow) begin
						$error("sample_row: expected %0d, actual %0d", e.srow, sample_row);
						errors++;
					end
					if (data_row !== e.drow) begin
						$error("data_row: expected %0d, actual %0d", e.drow, data_row);
						errors++;
					end
					if (position !== e.pos) begin
						$error("position: expected %0d, actual %0d", e.pos, position);
						errors++;
					end
					if (last_row !== e.last) begin
						$error("last_row: expected %0d, actual %0d", e.last, last_row);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				cols_reg = cfg_data;
				col_cnt = 0;
			end
			if (start && !busy) apply_item(cmd_t'(cmd), value);
		end
	end
endmodule

>>> test/tb_row_match_dedup_partition_top.sv
// ----------------------------------------------------------------------------
// tb_row_match_dedup_partition_top
// Drives directed and random data, sample, drain and clear items into the row
// matcher under several column settings, with random gaps, and gives the
// verdict from the failure count and the pending result count of the checker.
// ----------------------------------------------------------------------------
module tb_row_match_dedup_partition_top;
	import rmdp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic signed [31:0] value;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_data;
	logic               done;
	logic [2:0]         kind;
	logic [15:0]        sample_row;
	logic [7:0]         data_row;
	logic [15:0]        position;
	logic               last_row;
	int                 errors;
	int                 pending;

	bit                 steady;
	int unsigned        n_items;
	int unsigned        width;
	logic [31:0]        loaded[$][MAX_COLS];
	logic [31:0]        pool[4];

	row_match_dedup_partition_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.value(value), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
		.kind(kind), .sample_row(sample_row), .data_row(data_row),
		.position(position), .last_row(last_row)
	);

	rmdp_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.value(value), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
		.kind(kind), .sample_row(sample_row), .data_row(data_row),
		.position(position), .last_row(last_row), .errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send(cmd_t c, logic [31:0] v);
		if (!steady && $urandom_range(99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		value <= v;
		do @(posedge clk); while (busy);
		n_items++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_cols(logic [CFG_W-1:0] c);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		width = (c < 1) ? 1 : (c > MAX_COLS) ? MAX_COLS : c;
		send(CMD_CLEAR, $urandom);
		loaded.delete();
	endtask

	function automatic logic [31:0] pick();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 6) return pool[$urandom_range(3)];
		if (r == 6) return 32'h8000_0000;
		if (r == 7) return 32'h7FFF_FFFF;
		return $urandom;
	endfunction

	task automatic data_row_of(logic [31:0] a, logic [31:0] b);
		logic [31:0] r[MAX_COLS];
		for (int k = 0; k < MAX_COLS; k++) r[k] = (k == 0) ? a : (k == 1) ? b : pick();
		for (int k = 0; k < width; k++) send(CMD_DATA, r[k]);
		loaded.push_back(r);
	endtask

	task automatic sample_row_of(logic [31:0] r[MAX_COLS]);
		for (int k = 0; k < width; k++) send(CMD_SAMPLE, r[k]);
	endtask

	task automatic random_phase();
		int unsigned nd;
		int unsigned ns;
		logic [31:0] r[MAX_COLS];
		logic [CFG_W-1:0] choices[7];
		choices = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd15, 4'($urandom)};
		set_cols(choices[$urandom_range(6)]);
		nd = $urandom_range(1, 12);
		ns = $urandom_range(1, 14);
		for (int i = 0; i < nd; i++) data_row_of(pick(), pick());
		for (int i = 0; i < ns; i++) begin
			if ($urandom_range(9) < 6) r = loaded[$urandom_range(loaded.size() - 1)];
			else for (int k = 0; k < MAX_COLS; k++) r[k] = pick();
			if ($urandom_range(19) == 0)
				send(cmd_t'($urandom_range(CMD_DATA, CMD_DRAIN)), $urandom);
			sample_row_of(r);
		end
		for (int i = 0; i < nd + 1; i++) send(CMD_DRAIN, $urandom);
		if ($urandom_range(3) == 0) send(CMD_CLEAR, $urandom);
	endtask

	initial begin
		logic [31:0] r[MAX_COLS];
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_CLEAR;
		value = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		n_items = 0;
		width = MAX_COLS;
		pool = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h1234_8000};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Duplicate rows, extreme values, a mixed partial row and a drain past the end.
		set_cols(4'd2);
		send(CMD_DATA, 32'h8000_0000);
		send(CMD_DATA, 32'h7FFF_FFFF);
		send(CMD_DATA, 32'h0000_0000);
		send(CMD_DATA, 32'hFFFF_FFFF);
		send(CMD_DATA, 32'h8000_0000);
		send(CMD_DATA, 32'h7FFF_FFFF);
		send(CMD_DATA, 32'h5555_5555);
		send(CMD_SAMPLE, 32'h8000_0000);
		send(CMD_SAMPLE, 32'h7FFF_FFFF);
		send(CMD_SAMPLE, 32'h8000_0000);
		send(CMD_SAMPLE, 32'h7FFF_FFFF);
		send(CMD_SAMPLE, 32'h8000_0000);
		send(CMD_SAMPLE, 32'h7FFF_FFFF);
		send(CMD_SAMPLE, 32'h0000_0000);
		send(CMD_SAMPLE, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) send(CMD_DRAIN, 32'hAAAA_AAAA);

		// Store full, with the column count written as zero.
		set_cols(4'd0);
		for (int i = 0; i <= MAX_ROWS; i++) send(CMD_DATA, i);
		send(CMD_SAMPLE, 32'd7);
		for (int i = 0; i < 3; i++) send(CMD_DRAIN, '0);

		// A long run of kept samples behind two matched ones.
		set_cols(4'd1);
		steady = 1'b1;
		send(CMD_DATA, 32'd1);
		send(CMD_DATA, 32'd2);
		send(CMD_SAMPLE, 32'd1);
		send(CMD_SAMPLE, 32'd2);
		for (int i = 0; i < 200; i++) send(CMD_SAMPLE, 32'd3);
		for (int i = 0; i < 3; i++) send(CMD_DRAIN, '0);
		steady = 1'b0;

		set_cols(4'd15);
		for (int k = 0; k < MAX_COLS; k++) r[k] = $urandom;
		for (int k = 0; k < MAX_COLS; k++) send(CMD_DATA, r[k]);
		sample_row_of(r);
		send(CMD_DRAIN, '0);

		for (int ph = 0; n_items < 1700; ph++) begin
			steady = (ph >= 6 && ph < 10);
			random_phase();
		end
		steady = 1'b0;

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
